// ----- rtl/core/mt3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mt3_pkg;

  localparam int EW  = 32;
  localparam int FB  = 16;
  localparam int NL  = 9;
  localparam int PW  = 2 * EW;
  localparam int CW  = PW + 1;
  localparam int CMW = PW;
  localparam int DW  = 3 * EW + 2;
  localparam int DMW = DW - 1;
  localparam int SH  = 2 * FB;
  localparam int NW  = CMW + SH;
  localparam int XW  = (NW > DMW + EW) ? NW : DMW + EW;
  localparam int IDW = ((NL * EW + 7) / 8) * 8;
  localparam int ODW = (((NL + 1) * EW + 7) / 8) * 8;

  typedef logic signed [EW-1:0] ent_t;
  typedef ent_t [NL-1:0]        mat_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef cof_t [NL-1:0]        cof_mat_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic [DMW-1:0]       dmag_t;

  typedef struct packed {
    dmag_t           rem;
    logic [EW-1:0]   quo;
    logic [EW-1:0]   low;
  } lane_t;

  typedef lane_t [NL-1:0] lanes_t;

  typedef struct packed {
    logic            singular;
    ent_t            det_out;
    dmag_t           dmag;
    logic [NL-1:0]   neg;
    logic [NL-1:0]   ovf;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/core/mt3_cofactor.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mt3_cofactor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mt3_pkg::mat_t       mat_i,
  output logic                valid_o,
  output mt3_pkg::cof_mat_t   cof_o,
  output mt3_pkg::ent_t [2:0] row0_o
);
  import mt3_pkg::*;

  logic signed [PW-1:0] pp_q [NL];
  logic signed [PW-1:0] pn_q [NL];
  cof_mat_t             cof_q;
  ent_t [2:0]           row1_q;
  ent_t [2:0]           row2_q;
  logic                 v1_q;
  logic                 v2_q;

  for (genvar k = 0; k < NL; k++) begin : g_cof
    localparam int R  = k / 3;
    localparam int C  = k % 3;
    localparam int IP = ((R + 1) % 3) * 3 + (C + 1) % 3;
    localparam int IQ = ((R + 2) % 3) * 3 + (C + 2) % 3;
    localparam int JP = ((R + 1) % 3) * 3 + (C + 2) % 3;
    localparam int JQ = ((R + 2) % 3) * 3 + (C + 1) % 3;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pp_q[k]  <= $signed(mat_i[IP]) * $signed(mat_i[IQ]);
        pn_q[k]  <= $signed(mat_i[JP]) * $signed(mat_i[JQ]);
        cof_q[k] <= CW'(pp_q[k]) - CW'(pn_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row1_q <= mat_i[2:0];
      row2_q <= row1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign cof_o   = cof_q;
  assign row0_o  = row2_q;

endmodule
`default_nettype wire

// ----- rtl/core/mt3_det.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mt3_det (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mt3_pkg::cof_mat_t   cof_i,
  input  mt3_pkg::ent_t [2:0] row0_i,
  output logic                valid_o,
  output mt3_pkg::det_t       det_o,
  output mt3_pkg::cof_mat_t   cof_o
);
  import mt3_pkg::*;

  logic signed [PW:0] pl_q [3];
  logic signed [PW:0] ph_q [3];
  det_t               term_q [3];
  det_t               det_q;
  cof_mat_t           c3_q;
  cof_mat_t           c4_q;
  cof_mat_t           c5_q;
  logic               v3_q;
  logic               v4_q;
  logic               v5_q;

  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pl_q[j]   <= $signed(row0_i[j]) * $signed({1'b0, cof_i[j][EW-1:0]});
        ph_q[j]   <= $signed(row0_i[j]) * $signed(cof_i[j][CW-1:EW]);
        term_q[j] <= (DW'(ph_q[j]) <<< EW) + DW'(pl_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= term_q[0] + term_q[1] + term_q[2];
      c3_q  <= cof_i;
      c4_q  <= c3_q;
      c5_q  <= c4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign det_o   = det_q;
  assign cof_o   = c5_q;

endmodule
`default_nettype wire

// ----- rtl/core/mt3_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mt3_divider (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mt3_pkg::lanes_t lanes_i,
  input  mt3_pkg::side_t  side_i,
  output logic            valid_o,
  output mt3_pkg::lanes_t lanes_o,
  output mt3_pkg::side_t  side_o
);
  import mt3_pkg::*;

  lanes_t st_q [EW];
  side_t  sd_q [EW];
  logic   v_q  [EW];

  for (genvar s = 0; s < EW; s++) begin : g_step
    lanes_t src;
    lanes_t nxt;
    side_t  ssrc;
    logic   vsrc;

    if (s == 0) begin : g_first
      assign src  = lanes_i;
      assign ssrc = side_i;
      assign vsrc = valid_i;
    end else begin : g_next
      assign src  = st_q[s-1];
      assign ssrc = sd_q[s-1];
      assign vsrc = v_q[s-1];
    end

    always_comb begin
      logic [DMW:0] t;
      logic [DMW:0] diff;
      logic         ge;
      nxt = src;
      for (int l = 0; l < NL; l++) begin
        t    = {src[l].rem, src[l].low[EW-1]};
        diff = t - {1'b0, ssrc.dmag};
        ge   = (t >= {1'b0, ssrc.dmag});
        nxt[l].rem = ge ? diff[DMW-1:0] : t[DMW-1:0];
        nxt[l].quo = {src[l].quo[EW-2:0], ge};
        nxt[l].low = {src[l].low[EW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= nxt;
        sd_q[s] <= ssrc;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vsrc;
      end
    end
  end

  assign valid_o = v_q[EW-1];
  assign lanes_o = st_q[EW-1];
  assign side_o  = sd_q[EW-1];

endmodule
`default_nettype wire

// ----- rtl/core/matrix3_inverse.sv -----
// Inverse of a 3x3 matrix of signed Q16.16 entries by the adjugate method. Each input item
// carries the nine entries a00..a22 (row-major, a00 in the lowest bits); each output item
// carries the nine inverse entries r00..r22 and the determinant, every value rounded toward
// zero and saturated to 32 bits, with tuser high when the determinant is exactly zero, in
// which case all values are zero. The block takes one item per cycle and each item passes
// through 41 registers: one input register, two cofactor stages, three determinant stages,
// two normalizing stages, one restoring-division stage per quotient bit (32, nine lanes in
// parallel) and the output register. The whole pipeline holds while a finished item waits at
// the output.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22
  input  logic [mt3_pkg::IDW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, det_out
  output logic [mt3_pkg::ODW-1:0]  m_axis_tdata,
  // singular
  output logic                     m_axis_tuser
);
  import mt3_pkg::*;

  function automatic ent_t sat_mag(dmag_t m, logic neg);
    dmag_t lim;
    dmag_t v;
    lim = dmag_t'(1) << (EW - 1);
    if (!neg) lim = lim - dmag_t'(1);
    v = (m > lim) ? lim : m;
    if (neg) v = -v;
    return ent_t'(v[EW-1:0]);
  endfunction

  logic       en;
  mat_t       in_q;
  logic       v0_q;
  logic       cf_valid;
  cof_mat_t   cf_cof;
  ent_t [2:0] cf_row0;
  logic       dt_valid;
  det_t       dt_det;
  cof_mat_t   dt_cof;

  dmag_t          dmag6_q;
  logic           dneg6_q;
  logic           sing6_q;
  logic [CMW-1:0] cmag6_q [NL];
  logic [NL-1:0]  neg6_q;
  logic           v6_q;

  lanes_t lanes7_q;
  side_t  side7_q;
  logic   v7_q;

  logic   dv_valid;
  lanes_t dv_lanes;
  side_t  dv_side;

  mat_t   res_q;
  ent_t   det_q;
  logic   sing_q;
  logic   out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        in_q[k] <= s_axis_tdata[k*EW +: EW];
      end
    end
  end

  mt3_cofactor u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .mat_i   (in_q),
    .valid_o (cf_valid),
    .cof_o   (cf_cof),
    .row0_o  (cf_row0)
  );

  mt3_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cf_valid),
    .cof_i   (cf_cof),
    .row0_i  (cf_row0),
    .valid_o (dt_valid),
    .det_o   (dt_det),
    .cof_o   (dt_cof)
  );

  // Entry (i,j) of the inverse is built from cofactor (j,i).
  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag6_q <= dt_det[DW-1] ? DMW'(-dt_det) : DMW'(dt_det);
      dneg6_q <= dt_det[DW-1];
      sing6_q <= (dt_det == '0);
      for (int l = 0; l < NL; l++) begin
        cmag6_q[l] <= dt_cof[(l % 3) * 3 + l / 3][CW-1]
                    ? CMW'(-dt_cof[(l % 3) * 3 + l / 3])
                    : CMW'(dt_cof[(l % 3) * 3 + l / 3]);
        neg6_q[l]  <= dt_cof[(l % 3) * 3 + l / 3][CW-1] ^ dt_det[DW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        lanes7_q[l].rem <= DMW'((XW'(cmag6_q[l]) << SH) >> EW);
        lanes7_q[l].quo <= '0;
        lanes7_q[l].low <= EW'(XW'(cmag6_q[l]) << SH);
        side7_q.ovf[l]  <= ((XW'(cmag6_q[l]) << SH) >= (XW'(dmag6_q) << EW));
      end
      side7_q.neg      <= neg6_q;
      side7_q.dmag     <= dmag6_q;
      side7_q.singular <= sing6_q;
      side7_q.det_out  <= sat_mag(dmag6_q >> SH, dneg6_q);
    end
  end

  mt3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .lanes_i (lanes7_q),
    .side_i  (side7_q),
    .valid_o (dv_valid),
    .lanes_o (dv_lanes),
    .side_o  (dv_side)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        res_q[l] <= dv_side.singular ? ent_t'(0)
                  : sat_mag(dv_side.ovf[l] ? '1 : DMW'(dv_lanes[l].quo), dv_side.neg[l]);
      end
      det_q  <= dv_side.det_out;
      sing_q <= dv_side.singular;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v0_q    <= s_axis_tvalid;
      v6_q    <= dt_valid;
      v7_q    <= v6_q;
      out_v_q <= dv_valid;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int l = 0; l < NL; l++) begin
      m_axis_tdata[l*EW +: EW] = res_q[l];
    end
    m_axis_tdata[NL*EW +: EW] = det_q;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = sing_q;

endmodule
`default_nettype wire

// ----- rtl/core/mt3_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mt3_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic [mt3_pkg::IDW-1:0] s_axis_tdata,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [mt3_pkg::ODW-1:0] m_axis_tdata,
  input logic                    m_axis_tuser
);
  import mt3_pkg::*;

  a_sing_det : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[NL*EW +: EW] == '0)
    else $error("singular item with nonzero determinant");

  a_sing_ent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[NL*EW-1:0] == '0)
    else $error("singular item with nonzero entries");

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the output can move");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

endmodule

bind matrix3_inverse mt3_checker u_mt3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/matrix3_inverse_checker.sv -----
`timescale 1ns / 1ps
module matrix3_inverse_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [mt3_pkg::IDW-1:0]  s_axis_tdata,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [mt3_pkg::ODW-1:0]  m_axis_tdata,
  input  logic                     m_axis_tuser,
  output int                       fail_count_o,
  output int                       pending_o
);
  import mt3_pkg::*;

  typedef struct {
    logic [ODW-1:0] data;
    logic           singular;
  } inverse_t;

  inverse_t inverse_q[$];

  // Saturates an exact signed value to one output entry.
  function automatic logic [EW-1:0] clamp_entry(logic signed [255:0] v);
    logic signed [255:0] hi;
    logic signed [255:0] lo;
    hi = (256'sd1 <<< (EW - 1)) - 1;
    lo = -(256'sd1 <<< (EW - 1));
    if (v > hi) return hi[EW-1:0];
    if (v < lo) return lo[EW-1:0];
    return v[EW-1:0];
  endfunction

  function automatic inverse_t invert_matrix(logic [IDW-1:0] raw);
    logic signed [255:0] a[3][3];
    logic signed [255:0] cof[3][3];
    logic signed [255:0] det;
    logic signed [255:0] num;
    logic signed [255:0] quo;
    inverse_t res;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = $signed(raw[(r * 3 + c) * EW +: EW]);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r + 1) % 3][(c + 1) % 3] * a[(r + 2) % 3][(c + 2) % 3]
                  - a[(r + 1) % 3][(c + 2) % 3] * a[(r + 2) % 3][(c + 1) % 3];
    det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    res.data = '0;
    res.singular = (det == 0);
    if (det != 0) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          num = cof[j][i] <<< (2 * FB);
          quo = num / det;
          res.data[(i * 3 + j) * EW +: EW] = clamp_entry(quo);
        end
      res.data[9 * EW +: EW] = clamp_entry(det / (256'sd1 <<< (2 * FB)));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [EW-1:0] got, logic [EW-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = inverse_q.size();

  always @(posedge clk_i) begin
    inverse_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) inverse_q.push_back(invert_matrix(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < 10; k++)
            if (m_axis_tdata[k * EW +: EW] !== want.data[k * EW +: EW])
              report_mismatch($sformatf("field %0d", k), m_axis_tdata[k * EW +: EW],
                              want.data[k * EW +: EW]);
          if (m_axis_tuser !== want.singular)
            report_mismatch("singular", EW'(m_axis_tuser), EW'(want.singular));
        end
      end
    end
  end
endmodule

// ----- tb/matrix3_inverse_test.sv -----
`timescale 1ns / 1ps
module matrix3_inverse_test;
  import mt3_pkg::*;

  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT = 400000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [IDW-1:0] s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [ODW-1:0] m_axis_tdata;
  logic           m_axis_tuser;
  int             fail_count;
  int             pending;
  int             cycle_count = 0;
  bit             long_hold = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  matrix3_inverse dut (.*);

  matrix3_inverse_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls on its own pattern, with quiet stretches and one long hold.
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk_i);
        if (mode == 0) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) >= mode - 1);
      end
    end
  end

  function automatic logic [EW-1:0] pick_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'(signed'($urandom_range(0, 8)) - 4) << FB;
      4: return 32'(signed'($urandom_range(0, 512)) - 256);
      5: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDW-1:0] pick_matrix();
    logic [IDW-1:0] m;
    int src;
    int dst;
    for (int k = 0; k < NL; k++) m[k * EW +: EW] = pick_entry();
    // Copy a row onto another now and then so the determinant is zero.
    if ($urandom_range(0, 9) == 0) begin
      src = $urandom_range(0, 2);
      dst = (src + 1 + $urandom_range(0, 1)) % 3;
      m[dst * 3 * EW +: 3 * EW] = m[src * 3 * EW +: 3 * EW];
    end
    return m;
  endfunction

  task automatic send_matrix(logic [IDW-1:0] m);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= m;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  logic [IDW-1:0] directed_q[$];

  initial begin
    logic [IDW-1:0] m;
    int burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    m = '0;
    directed_q.push_back(m);
    for (int k = 0; k < 3; k++) m[(k * 4) * EW +: EW] = 32'h0001_0000;
    directed_q.push_back(m);
    for (int k = 0; k < 3; k++) m[(k * 4) * EW +: EW] = 32'h0000_0001;
    directed_q.push_back(m);
    for (int k = 0; k < 3; k++) m[(k * 4) * EW +: EW] = 32'h0000_0100;
    directed_q.push_back(m);
    for (int k = 0; k < 3; k++) m[(k * 4) * EW +: EW] = 32'h8000_0000;
    directed_q.push_back(m);
    for (int k = 0; k < 3; k++) m[(k * 4) * EW +: EW] = 32'h7fff_ffff;
    directed_q.push_back(m);
    directed_q.push_back({NL{32'h8000_0000}});
    directed_q.push_back({NL{32'h7fff_ffff}});
    directed_q.push_back({NL{32'hffff_ffff}});
    m = {NL{32'h8000_0000}};
    m[4 * EW +: EW] = 32'h7fff_ffff;
    m[8 * EW +: EW] = 32'h0000_0001;
    directed_q.push_back(m);
    m = '0;
    m[0 +: EW] = 32'h0000_0002;
    m[4 * EW +: EW] = 32'hfffe_0000;
    m[8 * EW +: EW] = 32'h0003_0000;
    m[1 * EW +: EW] = 32'h0001_8000;
    directed_q.push_back(m);
    for (int k = 0; k < 6; k++) directed_q.push_back(pick_matrix());
    foreach (directed_q[k]) send_matrix(directed_q[k]);

    // Pause until the pipeline has drained.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
        if (n == 400) long_hold = 1'b1;
        send_matrix(pick_matrix());
      end
      if ($urandom_range(0, 2) != 0) idle_sender();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
